@@ hw/rtl/stp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package stp_pkg;

  localparam int ErrW    = 25;
  localparam int MulAW   = 27;
  localparam int GainW   = 20;
  localparam int ProdW   = 48;
  localparam int SumW    = 48;
  localparam int IntegW  = 32;
  localparam int ThrW    = 16;
  localparam int CfgDW   = 23;
  localparam int CfgAW   = 3;
  localparam int PcW     = 3;

  // register indexes
  localparam logic [CfgAW-1:0] REG_DEAD_BAND       = 3'd0;
  localparam logic [CfgAW-1:0] REG_BEND_POINT      = 3'd1;
  localparam logic [CfgAW-1:0] REG_GAIN_INNER      = 3'd2;
  localparam logic [CfgAW-1:0] REG_GAIN_OUTER      = 3'd3;
  localparam logic [CfgAW-1:0] REG_INTEGRAL_GAIN   = 3'd4;
  localparam logic [CfgAW-1:0] REG_INTEGRAL_WINDOW = 3'd5;
  localparam logic [CfgAW-1:0] REG_INTEGRAL_LIMIT  = 3'd6;
  localparam logic [CfgAW-1:0] REG_OVERALL_GAIN    = 3'd7;

  // reset values
  localparam logic [22:0] RST_DEAD_BAND       = 23'd12288;
  localparam logic [22:0] RST_BEND_POINT      = 23'd32768;
  localparam logic [19:0] RST_GAIN_INNER      = 20'd2621;
  localparam logic [19:0] RST_GAIN_OUTER      = 20'd3277;
  localparam logic [19:0] RST_INTEGRAL_GAIN   = 20'd66;
  localparam logic [22:0] RST_INTEGRAL_WINDOW = 23'd20480;
  localparam logic [14:0] RST_INTEGRAL_LIMIT  = 15'd4915;
  localparam logic [19:0] RST_OVERALL_GAIN    = 20'd65536;

  // output shaping, q2.14
  localparam logic signed [42:0] THR_OFFSET = -43'sd3277;
  localparam logic signed [42:0] THR_MIN    = -43'sd13107;
  localparam logic signed [42:0] THR_MAX    = 43'sd16384;

  // multiplier a-operand select
  localparam logic [2:0] MA_NONE = 3'd0;
  localparam logic [2:0] MA_E    = 3'd1;
  localparam logic [2:0] MA_PROP = 3'd2;
  localparam logic [2:0] MA_BEND = 3'd3;
  localparam logic [2:0] MA_SLO  = 3'd4;
  localparam logic [2:0] MA_SHI  = 3'd5;

  // multiplier b-operand select
  localparam logic [1:0] MB_IG    = 2'd0;
  localparam logic [1:0] MB_PGAIN = 2'd1;
  localparam logic [1:0] MB_INNER = 2'd2;
  localparam logic [1:0] MB_OG    = 2'd3;

  // datapath operation
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_INTEG  = 3'd1;
  localparam logic [2:0] OP_SUMLD  = 3'd2;
  localparam logic [2:0] OP_SUMADD = 3'd3;
  localparam logic [2:0] OP_LOW    = 3'd4;
  localparam logic [2:0] OP_FINISH = 3'd5;
  localparam logic [2:0] OP_HOLD   = 3'd6;

  // sequencing
  localparam logic [1:0] J_NEXT = 2'd0;
  localparam logic [1:0] J_DB   = 2'd1;
  localparam logic [1:0] J_END  = 2'd2;

  // program steps
  localparam logic [PcW-1:0] PC_CHECK  = 3'd0;
  localparam logic [PcW-1:0] PC_INTEG  = 3'd1;
  localparam logic [PcW-1:0] PC_SUMLD  = 3'd2;
  localparam logic [PcW-1:0] PC_SUMADD = 3'd3;
  localparam logic [PcW-1:0] PC_SLO    = 3'd4;
  localparam logic [PcW-1:0] PC_SHI    = 3'd5;
  localparam logic [PcW-1:0] PC_FINISH = 3'd6;
  localparam logic [PcW-1:0] PC_HOLD   = 3'd7;

  typedef struct packed {
    logic [2:0]     ma;
    logic [1:0]     mb;
    logic [2:0]     op;
    logic [1:0]     jmp;
    logic [PcW-1:0] tgt;
  } ucw_t;

  function automatic ucw_t ucode(input logic [PcW-1:0] pc);
    ucw_t w;
    unique case (pc)
      PC_CHECK:  w = '{ma: MA_E,    mb: MB_IG,    op: OP_NONE,   jmp: J_DB,   tgt: PC_HOLD};
      PC_INTEG:  w = '{ma: MA_PROP, mb: MB_PGAIN, op: OP_INTEG,  jmp: J_NEXT, tgt: PC_CHECK};
      PC_SUMLD:  w = '{ma: MA_BEND, mb: MB_INNER, op: OP_SUMLD,  jmp: J_NEXT, tgt: PC_CHECK};
      PC_SUMADD: w = '{ma: MA_NONE, mb: MB_IG,    op: OP_SUMADD, jmp: J_NEXT, tgt: PC_CHECK};
      PC_SLO:    w = '{ma: MA_SLO,  mb: MB_OG,    op: OP_NONE,   jmp: J_NEXT, tgt: PC_CHECK};
      PC_SHI:    w = '{ma: MA_SHI,  mb: MB_OG,    op: OP_LOW,    jmp: J_NEXT, tgt: PC_CHECK};
      PC_FINISH: w = '{ma: MA_NONE, mb: MB_IG,    op: OP_FINISH, jmp: J_END,  tgt: PC_CHECK};
      PC_HOLD:   w = '{ma: MA_NONE, mb: MB_IG,    op: OP_HOLD,   jmp: J_END,  tgt: PC_CHECK};
      default:   w = '{ma: MA_NONE, mb: MB_IG,    op: OP_NONE,   jmp: J_END,  tgt: PC_CHECK};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/speed_to_throttle_pi_top.sv @@
// channel  dir  handshake              payload
// in       in   in_tvalid/in_tready    in_tdata: target_speed, measured_speed
// out      out  out_tvalid/out_tready  out_tdata: throttle; out_tuser: held
// cfg      in   cfg_wr_en              cfg_addr, cfg_wdata
//
// one word in flight; in the dead band the program jumps from the check step to the hold step
// the microcode program drives one shared 27x21 multiplier
// a new word is taken while the previous result still waits on out_tready
// the finish and hold steps stall while the output register is full
// rst_n is synchronous; it clears the sequencer, integral, last throttle and output valid, and resets the registers
`timescale 1ns / 1ps
`default_nettype none

module speed_to_throttle_pi_top
  import stp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [47:0]      in_tdata,   // target_speed[23:0], measured_speed[47:24]
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [15:0]           out_tdata,  // throttle[15:0]
  output logic                  out_tuser,  // held[0]
  input  wire logic             cfg_wr_en,
  input  wire logic [CfgAW-1:0] cfg_addr,
  input  wire logic [CfgDW-1:0] cfg_wdata
);

  logic [22:0] dead_band_r, bend_point_r, integral_window_r;
  logic [19:0] gain_inner_r, gain_outer_r, integral_gain_r, overall_gain_r;
  logic [14:0] integral_limit_r;

  logic                     busy_r;
  logic [PcW-1:0]           pc_r;
  logic signed [ErrW-1:0]   e_r;
  logic signed [ProdW-1:0]  prod_r;
  logic signed [SumW-1:0]   sum_r;
  logic [20:0]              t_r;
  logic signed [IntegW-1:0] integ_r;
  logic signed [ThrW-1:0]   last_r;
  logic                     out_valid_r;
  logic [ThrW-1:0]          out_thr_r;
  logic                     out_held_r;

  ucw_t                     ucw;
  logic                     accept;
  logic                     out_free;
  logic                     finish_go;
  logic [ErrW-1:0]          mag;
  logic                     outer, dead, in_win;
  logic signed [MulAW-1:0]  e27, bend27, mul_a;
  logic [GainW-1:0]         mul_b;
  logic signed [ProdW-1:0]  prod_nxt;
  logic signed [48:0]       ni, lim, ni_clamp;
  logic [47:0]              lo_sum;
  logic signed [47:0]       hi_sum;
  logic signed [42:0]       thr_off;
  logic signed [ThrW-1:0]   thr_q;

  assign ucw       = ucode(pc_r);
  assign in_tready = !busy_r;
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign finish_go = busy_r && (ucw.jmp == J_END) && out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_thr_r;
  assign out_tuser  = out_held_r;

  assign mag    = e_r[ErrW-1] ? ErrW'(-e_r) : ErrW'(e_r);
  assign outer  = mag > {2'b00, bend_point_r};
  assign dead   = mag < {2'b00, dead_band_r};
  assign in_win = mag < {2'b00, integral_window_r};
  assign e27    = {{2{e_r[ErrW-1]}}, e_r};
  assign bend27 = {4'b0000, bend_point_r};

  always_comb begin
    case (ucw.ma)
      MA_E:    mul_a = e27;
      MA_PROP: mul_a = outer ? (e_r[ErrW-1] ? e27 + bend27 : e27 - bend27) : e27;
      MA_BEND: mul_a = outer ? (e_r[ErrW-1] ? -bend27 : bend27) : '0;
      MA_SLO:  mul_a = {3'b000, sum_r[23:0]};
      MA_SHI:  mul_a = {{3{sum_r[SumW-1]}}, sum_r[47:24]};
      default: mul_a = '0;
    endcase
    case (ucw.mb)
      MB_IG:    mul_b = integral_gain_r;
      MB_PGAIN: mul_b = outer ? gain_outer_r : gain_inner_r;
      MB_INNER: mul_b = gain_inner_r;
      default:  mul_b = overall_gain_r;
    endcase
  end

  assign prod_nxt = mul_a * $signed({1'b0, mul_b});

  // integral update with symmetric clamp
  assign ni  = {{17{integ_r[IntegW-1]}}, integ_r} + {prod_r[ProdW-1], prod_r};
  assign lim = {20'd0, integral_limit_r, 14'd0};
  always_comb begin
    if (ni > lim) begin
      ni_clamp = lim;
    end else if (ni < -lim) begin
      ni_clamp = -lim;
    end else begin
      ni_clamp = ni;
    end
  end

  // rounding: low partial carries into the high partial
  assign lo_sum  = prod_r + 48'h0000_2000_0000;
  assign hi_sum  = prod_r + $signed({27'd0, t_r});
  assign thr_off = {hi_sum[47], hi_sum[47:6]} + THR_OFFSET;
  always_comb begin
    if (thr_off > THR_MAX) begin
      thr_q = ThrW'(THR_MAX);
    end else if (thr_off < THR_MIN) begin
      thr_q = ThrW'(THR_MIN);
    end else begin
      thr_q = thr_off[ThrW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_band_r       <= RST_DEAD_BAND;
      bend_point_r      <= RST_BEND_POINT;
      gain_inner_r      <= RST_GAIN_INNER;
      gain_outer_r      <= RST_GAIN_OUTER;
      integral_gain_r   <= RST_INTEGRAL_GAIN;
      integral_window_r <= RST_INTEGRAL_WINDOW;
      integral_limit_r  <= RST_INTEGRAL_LIMIT;
      overall_gain_r    <= RST_OVERALL_GAIN;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_DEAD_BAND:       dead_band_r       <= cfg_wdata;
        REG_BEND_POINT:      bend_point_r      <= cfg_wdata;
        REG_GAIN_INNER:      gain_inner_r      <= cfg_wdata[19:0];
        REG_GAIN_OUTER:      gain_outer_r      <= cfg_wdata[19:0];
        REG_INTEGRAL_GAIN:   integral_gain_r   <= cfg_wdata[19:0];
        REG_INTEGRAL_WINDOW: integral_window_r <= cfg_wdata;
        REG_INTEGRAL_LIMIT:  integral_limit_r  <= cfg_wdata[14:0];
        REG_OVERALL_GAIN:    overall_gain_r    <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  // sequencer and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= PC_CHECK;
      integ_r     <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (finish_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        busy_r <= 1'b1;
        pc_r   <= PC_CHECK;
      end else if (busy_r) begin
        if (ucw.op == OP_INTEG) begin
          integ_r <= in_win ? IntegW'(ni_clamp) : '0;
        end
        unique case (ucw.jmp)
          J_DB:    pc_r <= dead ? ucw.tgt : pc_r + 1'b1;
          J_END: begin
            if (out_free) begin
              busy_r <= 1'b0;
              if (ucw.op == OP_FINISH) begin
                last_r <= thr_q;
              end
            end
          end
          default: pc_r <= pc_r + 1'b1;
        endcase
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    if (accept) begin
      e_r <= {in_tdata[23], in_tdata[23:0]} - {in_tdata[47], in_tdata[47:24]};
    end
    if (busy_r) begin
      if (ucw.ma != MA_NONE) begin
        prod_r <= prod_nxt;
      end
      case (ucw.op)
        OP_SUMLD:  sum_r <= prod_r + {{16{integ_r[IntegW-1]}}, integ_r};
        OP_SUMADD: sum_r <= sum_r + prod_r;
        OP_LOW:    t_r   <= lo_sum[44:24];
        OP_FINISH: begin
          if (out_free) begin
            out_thr_r  <= thr_q;
            out_held_r <= 1'b0;
          end
        end
        OP_HOLD: begin
          if (out_free) begin
            out_thr_r  <= last_r;
            out_held_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/stp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tuser
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

  // throttle always inside the clamp range
  a_thr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata) >= -16'sd13107) && ($signed(out_tdata) <= 16'sd16384))
    else $error("throttle out of range");

  // one word in flight
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while busy");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind speed_to_throttle_pi_top stp_checker u_stp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

@@ bench/throttle_checker.sv @@
`timescale 1ns / 1ps

module throttle_checker
  import stp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  input  wire logic             in_tready,
  input  wire logic [47:0]      in_tdata,   // target_speed[23:0], measured_speed[47:24]
  input  wire logic             out_tvalid,
  input  wire logic             out_tready,
  input  wire logic [15:0]      out_tdata,  // throttle[15:0]
  input  wire logic             out_tuser,  // held[0]
  input  wire logic             cfg_wr_en,
  input  wire logic [CfgAW-1:0] cfg_addr,
  input  wire logic [CfgDW-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    due_count,
  output int                    checked_count,
  output int                    held_count
);

  typedef struct packed {
    logic [15:0] throttle;
    logic        held;
  } throttle_t;

  throttle_t   throttle_due[$];

  logic [22:0] dead_band;
  logic [22:0] bend_point;
  logic [19:0] gain_inner;
  logic [19:0] gain_outer;
  logic [19:0] integral_gain;
  logic [22:0] integral_window;
  logic [14:0] integral_limit;
  logic [19:0] overall_gain;

  longint      integ;
  logic [15:0] last_thr;
  int          fails;
  int          checked;
  int          holds;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fails++;
  endtask

  task automatic predict_throttle(input logic [47:0] word);
    longint             e;
    longint             mag;
    longint             bend;
    longint             p;
    longint             lim;
    longint             ni;
    longint             thr;
    logic signed [71:0] wide_sum;
    logic signed [71:0] wide_gain;
    logic signed [71:0] scaled;
    throttle_t          r;
    e = longint'($signed(word[23:0])) - longint'($signed(word[47:24]));
    mag = (e < 0) ? -e : e;
    bend = longint'(bend_point);
    if (mag < longint'(dead_band)) begin
      r.throttle = last_thr;
      r.held = 1'b1;
    end else begin
      if (mag > bend) begin
        if (e > 0) begin
          p = longint'(gain_inner) * bend + longint'(gain_outer) * (e - bend);
        end else begin
          p = -(longint'(gain_inner) * bend) + longint'(gain_outer) * (e + bend);
        end
      end else begin
        p = longint'(gain_inner) * e;
      end
      if (mag < longint'(integral_window)) begin
        lim = longint'(integral_limit) <<< 14;
        ni = integ + e * longint'(integral_gain);
        if (ni > lim) ni = lim;
        if (ni < -lim) ni = -lim;
        integ = ni;
        p += ni;
      end else begin
        integ = 0;
      end
      wide_sum = 72'(p);
      wide_gain = {52'd0, overall_gain};
      scaled = wide_sum * wide_gain;
      scaled = (scaled >>> 16) + 72'sd8192;
      scaled = scaled >>> 14;
      thr = longint'(scaled) + longint'(THR_OFFSET);
      if (thr > longint'(THR_MAX)) thr = longint'(THR_MAX);
      if (thr < longint'(THR_MIN)) thr = longint'(THR_MIN);
      last_thr = thr[15:0];
      r.throttle = thr[15:0];
      r.held = 1'b0;
    end
    throttle_due.push_back(r);
  endtask

  always @(posedge clk) begin
    throttle_t oldest;
    if (!rst_n) begin
      dead_band = RST_DEAD_BAND;
      bend_point = RST_BEND_POINT;
      gain_inner = RST_GAIN_INNER;
      gain_outer = RST_GAIN_OUTER;
      integral_gain = RST_INTEGRAL_GAIN;
      integral_window = RST_INTEGRAL_WINDOW;
      integral_limit = RST_INTEGRAL_LIMIT;
      overall_gain = RST_OVERALL_GAIN;
      integ = 0;
      last_thr = '0;
      throttle_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (throttle_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word throttle=%0d held=%0b",
                                    $signed(out_tdata), out_tuser));
        end else begin
          oldest = throttle_due.pop_front();
          checked++;
          if (oldest.held) holds++;
          if (out_tdata !== oldest.throttle) begin
            report_mismatch($sformatf("throttle %0d, predicted %0d",
                                      $signed(out_tdata), $signed(oldest.throttle)));
          end
          if (out_tuser !== oldest.held) begin
            report_mismatch($sformatf("held %b, predicted %b", out_tuser, oldest.held));
          end
        end
      end
      if (in_tvalid && in_tready) predict_throttle(in_tdata);
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_DEAD_BAND:       dead_band = cfg_wdata[22:0];
          REG_BEND_POINT:      bend_point = cfg_wdata[22:0];
          REG_GAIN_INNER:      gain_inner = cfg_wdata[19:0];
          REG_GAIN_OUTER:      gain_outer = cfg_wdata[19:0];
          REG_INTEGRAL_GAIN:   integral_gain = cfg_wdata[19:0];
          REG_INTEGRAL_WINDOW: integral_window = cfg_wdata[22:0];
          REG_INTEGRAL_LIMIT:  integral_limit = cfg_wdata[14:0];
          REG_OVERALL_GAIN:    overall_gain = cfg_wdata[19:0];
          default: ;
        endcase
      end
    end
    fail_count <= fails;
    due_count <= throttle_due.size();
    checked_count <= checked;
    held_count <= holds;
  end

endmodule

@@ bench/speed_to_throttle_pi_top_test.sv @@
`timescale 1ns / 1ps

module speed_to_throttle_pi_top_test;
  import stp_pkg::*;

  typedef struct {
    logic [22:0] dead_band;
    logic [22:0] bend_point;
    logic [19:0] gain_inner;
    logic [19:0] gain_outer;
    logic [19:0] integral_gain;
    logic [22:0] integral_window;
    logic [14:0] integral_limit;
    logic [19:0] overall_gain;
  } setting_t;

  localparam longint MaxErr = 64'sd16777215;
  localparam int      Phases = 11;
  localparam int      PhaseWords = 170;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [47:0]      in_tdata = '0;   // target_speed[23:0], measured_speed[47:24]
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [15:0]      out_tdata;       // throttle[15:0]
  logic             out_tuser;       // held[0]
  logic             cfg_wr_en = 1'b0;
  logic [CfgAW-1:0] cfg_addr = '0;
  logic [CfgDW-1:0] cfg_wdata = '0;

  int               fail_count;
  int               due_count;
  int               checked_count;
  int               held_count;

  setting_t         cur;
  longint           drift;
  int               sent;
  int               settings_done;

  speed_to_throttle_pi_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  throttle_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .due_count     (due_count),
    .checked_count (checked_count),
    .held_count    (held_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("timeout with %0d words outstanding", due_count);
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random stalls, quiet stretches and two long hold-offs
  initial begin
    int taken;
    int gap;
    taken = 0;
    @(posedge clk);
    forever begin
      if (taken == 400 || taken == 1300) begin
        out_tready <= 1'b0;
        repeat (150) @(posedge clk);
      end
      gap = ((taken % 160) < 40) ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      taken++;
    end
  end

  task automatic send_word(input logic [23:0] target, input logic [23:0] measured);
    int gap;
    gap = ((sent % 200) < 50) ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {measured, target};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_error(input longint e);
    longint lo;
    longint hi;
    longint m;
    longint t;
    if (e > MaxErr) e = MaxErr;
    if (e < -MaxErr) e = -MaxErr;
    lo = -64'sd8388608;
    hi = 64'sd8388607;
    if (-64'sd8388608 - e > lo) lo = -64'sd8388608 - e;
    if (64'sd8388607 - e < hi) hi = 64'sd8388607 - e;
    m = lo + longint'($urandom_range(0, int'(hi - lo)));
    t = m + e;
    send_word(t[23:0], m[23:0]);
  endtask

  task automatic pause_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgAW-1:0] idx, input logic [CfgDW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_setting(input setting_t s);
    write_reg(REG_DEAD_BAND, s.dead_band);
    write_reg(REG_BEND_POINT, s.bend_point);
    write_reg(REG_GAIN_INNER, s.gain_inner);
    write_reg(REG_GAIN_OUTER, s.gain_outer);
    write_reg(REG_INTEGRAL_GAIN, s.integral_gain);
    write_reg(REG_INTEGRAL_WINDOW, s.integral_window);
    write_reg(REG_INTEGRAL_LIMIT, s.integral_limit);
    write_reg(REG_OVERALL_GAIN, s.overall_gain);
    cfg_wr_en <= 1'b0;
    cur = s;
    settings_done++;
  endtask

  function automatic logic [22:0] pick_threshold();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return 23'($urandom_range(0, 4096));
      default: return 23'($urandom_range(0, 131072));
    endcase
  endfunction

  function automatic logic [19:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return 20'($urandom_range(0, 4096));
      default: return 20'($urandom_range(0, 262144));
    endcase
  endfunction

  function automatic setting_t rand_setting();
    setting_t s;
    s.dead_band = pick_threshold();
    s.bend_point = pick_threshold();
    s.gain_inner = pick_gain();
    s.gain_outer = pick_gain();
    s.integral_gain = pick_gain();
    s.integral_window = pick_threshold();
    case ($urandom_range(0, 5))
      0:       s.integral_limit = '0;
      1:       s.integral_limit = '1;
      2:       s.integral_limit = 15'd16384;
      default: s.integral_limit = 15'($urandom_range(0, 16384));
    endcase
    s.overall_gain = pick_gain();
    return s;
  endfunction

  function automatic longint pick_error(input int kind);
    longint mag;
    longint sgn;
    longint reach;
    int     off;
    off = $urandom_range(0, 4);
    sgn = $urandom_range(0, 1) ? 64'sd1 : -64'sd1;
    case (kind)
      0, 1: mag = longint'(cur.dead_band) + off - 2;
      2, 3: mag = longint'(cur.bend_point) + off - 2;
      4, 5: mag = longint'(cur.integral_window) + off - 2;
      6, 7, 8, 9: begin
        if (cur.integral_window > cur.dead_band) begin
          mag = longint'($urandom_range(cur.dead_band, cur.integral_window - 1));
        end else begin
          mag = longint'($urandom_range(0, 65536));
        end
        sgn = ($urandom_range(0, 3) == 0) ? -drift : drift;
      end
      13: mag = longint'($urandom_range(0, 255));
      default: begin
        reach = cur.dead_band;
        if (cur.bend_point > reach) reach = cur.bend_point;
        if (cur.integral_window > reach) reach = cur.integral_window;
        mag = longint'($urandom_range(0, int'(2 * reach + 64)));
      end
    endcase
    if (mag < 0) mag = 0;
    return sgn * mag;
  endfunction

  initial begin
    setting_t s;
    int       kind;
    int       guard;
    sent = 0;
    settings_done = 0;
    drift = 1;
    cur.dead_band = RST_DEAD_BAND;
    cur.bend_point = RST_BEND_POINT;
    cur.gain_inner = RST_GAIN_INNER;
    cur.gain_outer = RST_GAIN_OUTER;
    cur.integral_gain = RST_INTEGRAL_GAIN;
    cur.integral_window = RST_INTEGRAL_WINDOW;
    cur.integral_limit = RST_INTEGRAL_LIMIT;
    cur.overall_gain = RST_OVERALL_GAIN;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: field extremes and every threshold edge
    send_word(24'h7FFFFF, 24'h800000);
    send_word(24'h800000, 24'h7FFFFF);
    send_word(24'h000000, 24'h000000);
    send_error(longint'(cur.dead_band) - 1);
    send_error(-(longint'(cur.dead_band) - 1));
    send_error(longint'(cur.dead_band));
    send_error(-longint'(cur.dead_band));
    send_error(longint'(cur.bend_point));
    send_error(longint'(cur.bend_point) + 1);
    send_error(-longint'(cur.bend_point));
    send_error(-longint'(cur.bend_point) - 1);
    send_error(longint'(cur.integral_window) - 1);
    send_error(longint'(cur.integral_window) - 1);
    send_error(longint'(cur.integral_window) - 1);
    send_error(longint'(cur.integral_window));
    send_error(-(longint'(cur.integral_window) - 1));
    send_error(-(longint'(cur.integral_window) - 1));
    send_error(-longint'(cur.integral_window));
    send_error(0);
    send_word(24'hFFFFFF, 24'hFFFFFF);

    for (int ph = 0; ph < Phases; ph++) begin
      pause_input();
      case (ph)
        0: begin
          s.dead_band = '1;
          s.bend_point = '1;
          s.gain_inner = '1;
          s.gain_outer = '1;
          s.integral_gain = '1;
          s.integral_window = '1;
          s.integral_limit = '1;
          s.overall_gain = '1;
        end
        1: begin
          s.dead_band = '0;
          s.bend_point = '0;
          s.gain_inner = '0;
          s.gain_outer = '0;
          s.integral_gain = '0;
          s.integral_window = '0;
          s.integral_limit = '0;
          s.overall_gain = '0;
        end
        2: begin
          s = rand_setting();
          s.dead_band = 23'($urandom_range(0, 64));
          s.integral_gain = '1;
          s.integral_window = '1;
          s.integral_limit = '1;
        end
        default: s = rand_setting();
      endcase
      apply_setting(s);
      drift = $urandom_range(0, 1) ? 64'sd1 : -64'sd1;
      for (int k = 0; k < PhaseWords; k++) begin
        if (k == PhaseWords / 2) pause_input();
        kind = $urandom_range(0, 15);
        if (kind >= 14) begin
          send_word(24'($urandom), 24'($urandom));
        end else begin
          send_error(pick_error(kind));
        end
      end
    end

    in_tvalid <= 1'b0;
    guard = 0;
    while (due_count != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (16) @(posedge clk);
    if (due_count != 0) $display("%0d predicted words never came out", due_count);
    $display("run covered %0d words over %0d register settings plus reset values",
             sent, settings_done);
    $display("%0d results checked, %0d of them dead-band holds, %0d mismatches",
             checked_count, held_count, fail_count);
    if (fail_count == 0 && due_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
